>>> src/seed_chain_gap_score_filter_unit_macros.svh
// ----------------------------------------------------------------------------
// seed chain gap score filter assertion macros
// shared property wrappers, sampled on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef SEED_CHAIN_GAP_SCORE_FILTER_UNIT_MACROS_SVH
`define SEED_CHAIN_GAP_SCORE_FILTER_UNIT_MACROS_SVH

// condition must hold at every edge out of reset
`define SCGSF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define SCGSF_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> src/scgsf_pkg.sv
// ----------------------------------------------------------------------------
// scgsf_pkg
// types and constants shared by the seed chain gap score filter
// ----------------------------------------------------------------------------
package scgsf_pkg;

    localparam int POS_W      = 32;
    localparam int LEN_W      = 20;
    localparam int SCORE_W    = 48;
    localparam int IDX_OUT_W  = 12;
    localparam int TERM_W     = 41;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int QDEPTH     = 8;
    localparam int QPTR_W     = 3;
    localparam int QCNT_W     = 4;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_SCORE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_OPEN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_EXTEND     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP_AREA   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OPTIMISTIC_GAP = 3'd4;

    typedef struct packed {
        logic [7:0]       match_score;
        logic [7:0]       gap_open;
        logic [7:0]       gap_extend;
        logic [POS_W-1:0] max_gap_area;
        logic             optimistic_gap;
    } scgsf_cfg_t;

    // one classified seed, handed from front to back
    typedef struct packed {
        logic [TERM_W-1:0] add_term;
        logic [TERM_W-1:0] gap_cost;
        logic              area_cut;
        logic              first;
        logic              last;
    } scgsf_entry_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] chain_first_index;
        logic [IDX_OUT_W-1:0] chain_last_index;
        logic [SCORE_W-1:0]   chain_score;
    } scgsf_result_t;

endpackage

>>> src/scgsf_front.sv
// ----------------------------------------------------------------------------
// scgsf_front
// accepts seeds, derives gap sizes, reward and penalty terms and the area cut
// ----------------------------------------------------------------------------
module scgsf_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [scgsf_pkg::POS_W-1:0]           query_start,
    input  logic [scgsf_pkg::POS_W-1:0]           ref_start,
    input  logic [scgsf_pkg::LEN_W-1:0]           seed_length,
    input  logic                                  first_seed,
    input  logic                                  last_seed,
    input  scgsf_pkg::scgsf_cfg_t                 cfg,
    input  logic [scgsf_pkg::QCNT_W-1:0]          q_count,
    output logic                                  push,
    output scgsf_pkg::scgsf_entry_t               push_entry
);

    localparam int POS_W  = scgsf_pkg::POS_W;
    localparam int LEN_W  = scgsf_pkg::LEN_W;
    localparam int TERM_W = scgsf_pkg::TERM_W;
    localparam int QCNT_W = scgsf_pkg::QCNT_W;

    logic accept;

    logic [POS_W-1:0] prev_q_reg, prev_r_reg;
    logic [LEN_W-1:0] prev_len_reg;

    logic v1_reg, v2_reg, v3_reg;

    // stage 1
    logic [POS_W-1:0] s1_dq_reg, s1_dr_reg, s1_gx_reg, s1_gy_reg;
    logic [LEN_W-1:0] s1_len_reg;
    logic             s1_first_reg, s1_last_reg;
    // stage 2
    logic [POS_W-1:0] s2_gap_reg, s2_min_reg, s2_gx_reg, s2_gy_reg;
    logic [LEN_W-1:0] s2_len_reg;
    logic             s2_first_reg, s2_last_reg;
    // stage 3: products
    logic [LEN_W+7:0]   s3_len_prod_reg;
    logic [POS_W+7:0]   s3_min_prod_reg;
    logic [POS_W+7:0]   s3_gap_prod_reg;
    logic [2*POS_W-1:0] s3_area_reg;
    logic               s3_first_reg, s3_last_reg;

    logic [POS_W-1:0] dq_next, dr_next, gx_next, gy_next;
    logic [POS_W:0]   pq_end, pr_end, qs_ext, rs_ext, gy_diff, gx_diff;
    logic [QCNT_W:0]  credit_used;

    // queue slots are reserved for everything still in the stages
    assign credit_used = {1'b0, q_count} + (QCNT_W+1)'(v1_reg) + (QCNT_W+1)'(v2_reg)
                       + (QCNT_W+1)'(v3_reg);
    assign in_ready = credit_used < (QCNT_W+1)'(scgsf_pkg::QDEPTH);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        dq_next = (query_start > prev_q_reg) ? query_start - prev_q_reg : '0;
        dr_next = (ref_start > prev_r_reg) ? ref_start - prev_r_reg : '0;
        pq_end  = {1'b0, prev_q_reg} + (POS_W+1)'(prev_len_reg);
        pr_end  = {1'b0, prev_r_reg} + (POS_W+1)'(prev_len_reg);
        qs_ext  = {1'b0, query_start};
        rs_ext  = {1'b0, ref_start};
        gy_diff = qs_ext - pq_end;
        gx_diff = rs_ext - pr_end;
        gy_next = (qs_ext < pq_end) ? '0 : gy_diff[POS_W-1:0];
        gx_next = (rs_ext < pr_end) ? '0 : gx_diff[POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_q_reg   <= '0;
            prev_r_reg   <= '0;
            prev_len_reg <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (accept)
            begin
                prev_q_reg   <= query_start;
                prev_r_reg   <= ref_start;
                prev_len_reg <= seed_length;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dq_reg    <= dq_next;
        s1_dr_reg    <= dr_next;
        s1_gx_reg    <= gx_next;
        s1_gy_reg    <= gy_next;
        s1_len_reg   <= seed_length;
        s1_first_reg <= first_seed;
        s1_last_reg  <= last_seed;

        // gap is the distance off the diagonal, the diagonal part is the shorter side
        s2_gap_reg   <= (s1_dq_reg > s1_dr_reg) ? s1_dq_reg - s1_dr_reg
                                                : s1_dr_reg - s1_dq_reg;
        s2_min_reg   <= (s1_dq_reg < s1_dr_reg) ? s1_dq_reg : s1_dr_reg;
        s2_gx_reg    <= s1_gx_reg;
        s2_gy_reg    <= s1_gy_reg;
        s2_len_reg   <= s1_len_reg;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;

        s3_len_prod_reg <= (LEN_W+8)'(s2_len_reg) * (LEN_W+8)'(cfg.match_score);
        s3_min_prod_reg <= (POS_W+8)'(s2_min_reg) * (POS_W+8)'(cfg.match_score);
        s3_gap_prod_reg <= (POS_W+8)'(s2_gap_reg) * (POS_W+8)'(cfg.gap_extend);
        s3_area_reg     <= (2*POS_W)'(s2_gx_reg) * (2*POS_W)'(s2_gy_reg);
        s3_first_reg    <= s2_first_reg;
        s3_last_reg     <= s2_last_reg;
    end

    always_comb
    begin
        push = v3_reg;
        // a first seed only takes its own match reward
        push_entry.add_term = TERM_W'(s3_len_prod_reg)
                            + ((cfg.optimistic_gap && !s3_first_reg)
                               ? TERM_W'(s3_min_prod_reg) : '0);
        push_entry.gap_cost = TERM_W'(s3_gap_prod_reg)
                            + ((s3_gap_prod_reg != '0) ? TERM_W'(cfg.gap_open) : '0);
        push_entry.area_cut = (cfg.max_gap_area != '0)
                            && (s3_area_reg > (2*POS_W)'(cfg.max_gap_area));
        push_entry.first    = s3_first_reg;
        push_entry.last     = s3_last_reg;
    end

endmodule

>>> src/scgsf_queue.sv
// ----------------------------------------------------------------------------
// scgsf_queue
// small register fifo between front and back
// ----------------------------------------------------------------------------
module scgsf_queue
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  scgsf_pkg::scgsf_entry_t       push_entry,
    input  logic                          pop,
    output scgsf_pkg::scgsf_entry_t       head,
    output logic [scgsf_pkg::QCNT_W-1:0]  count
);

    localparam int QPTR_W = scgsf_pkg::QPTR_W;
    localparam int QCNT_W = scgsf_pkg::QCNT_W;

    scgsf_pkg::scgsf_entry_t entries [scgsf_pkg::QDEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_entry;
    end

    assign head  = entries[rd_ptr_reg];
    assign count = count_reg;

endmodule

>>> src/scgsf_back.sv
// ----------------------------------------------------------------------------
// scgsf_back
// running chain score update, best chain tracking and result register
// ----------------------------------------------------------------------------
module scgsf_back
#(
    parameter int MAX_SEEDS = 4096
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  scgsf_pkg::scgsf_entry_t       head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output scgsf_pkg::scgsf_result_t      out_data
);

    localparam int SCORE_W   = scgsf_pkg::SCORE_W;
    localparam int IDX_OUT_W = scgsf_pkg::IDX_OUT_W;
    localparam int IDX_W     = $clog2(MAX_SEEDS);
    localparam logic [IDX_W-1:0] SEED_LIMIT = IDX_W'(MAX_SEEDS - 1);

    logic [SCORE_W-1:0] running_score_reg, running_score_next;
    logic [IDX_W-1:0]   seed_counter_reg, seed_counter_next;
    logic [IDX_W-1:0]   pending_start_reg, pending_start_next;

    logic               b1_valid_reg, b1_valid_next;
    logic [SCORE_W-1:0] b1_score_reg;
    logic [IDX_W-1:0]   b1_first_idx_reg, b1_last_idx_reg;
    logic               b1_first_reg, b1_last_reg;

    logic [SCORE_W-1:0] best_score_reg, best_score_next;
    logic [IDX_W-1:0]   best_first_reg, best_first_next;
    logic [IDX_W-1:0]   best_last_reg, best_last_next;

    logic                     out_valid_reg, out_valid_next;
    scgsf_pkg::scgsf_result_t out_data_reg, out_data_next;

    logic [SCORE_W:0]         sum;
    logic [SCORE_W-1:0]       sat, gap_ext;
    logic                     cut, b1_adv, emit;
    logic [IDX_W-1:0]         counter_inc;
    logic [IDX_W+IDX_OUT_W-1:0] first_wide, last_wide;

    // score recurrence on the queue head
    always_comb
    begin
        sum         = {1'b0, running_score_reg} + (SCORE_W+1)'(head.add_term);
        sat         = sum[SCORE_W] ? scgsf_pkg::SCORE_MAX : sum[SCORE_W-1:0];
        gap_ext     = SCORE_W'(head.gap_cost);
        cut         = head.area_cut || (sat < gap_ext);
        counter_inc = (seed_counter_reg < SEED_LIMIT) ? seed_counter_reg + 1'b1
                                                      : seed_counter_reg;
        if (head.first)
        begin
            running_score_next = SCORE_W'(head.add_term);
            seed_counter_next  = '0;
            pending_start_next = '0;
        end
        else
        begin
            running_score_next = cut ? '0 : sat - gap_ext;
            seed_counter_next  = counter_inc;
            pending_start_next = cut ? counter_inc : pending_start_reg;
        end
    end

    // a last seed waits here while the result register is still full
    assign b1_adv = b1_valid_reg && (!b1_last_reg || !out_valid_reg || out_ready);
    assign pop    = q_valid && (!b1_valid_reg || b1_adv);
    assign emit   = b1_adv && b1_last_reg;

    always_comb
    begin
        b1_valid_next = pop ? 1'b1 : (b1_adv ? 1'b0 : b1_valid_reg);

        best_score_next = best_score_reg;
        best_first_next = best_first_reg;
        best_last_next  = best_last_reg;
        // strictly larger replaces the best chain, a first seed always does
        if (b1_adv && (b1_first_reg || (b1_score_reg > best_score_reg)))
        begin
            best_score_next = b1_score_reg;
            best_first_next = b1_first_idx_reg;
            best_last_next  = b1_last_idx_reg;
        end

        first_wide = (IDX_W+IDX_OUT_W)'(best_first_next);
        last_wide  = (IDX_W+IDX_OUT_W)'(best_last_next);

        out_valid_next = emit || (out_valid_reg && !out_ready);
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_data_next.chain_first_index = first_wide[IDX_OUT_W-1:0];
            out_data_next.chain_last_index  = last_wide[IDX_OUT_W-1:0];
            out_data_next.chain_score       = best_score_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_score_reg <= '0;
            seed_counter_reg  <= '0;
            pending_start_reg <= '0;
            b1_valid_reg      <= 1'b0;
            best_score_reg    <= '0;
            best_first_reg    <= '0;
            best_last_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            b1_valid_reg   <= b1_valid_next;
            best_score_reg <= best_score_next;
            best_first_reg <= best_first_next;
            best_last_reg  <= best_last_next;
            out_valid_reg  <= out_valid_next;
            if (pop)
            begin
                running_score_reg <= running_score_next;
                seed_counter_reg  <= seed_counter_next;
                pending_start_reg <= pending_start_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (pop)
        begin
            b1_score_reg     <= running_score_next;
            b1_first_idx_reg <= pending_start_next;
            b1_last_idx_reg  <= seed_counter_next;
            b1_first_reg     <= head.first;
            b1_last_reg      <= head.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> src/seed_chain_gap_score_filter_unit.sv
// ----------------------------------------------------------------------------
// seed_chain_gap_score_filter_unit
// kadane-style chaining of sorted seeds with gap penalties, best chain output
// ----------------------------------------------------------------------------
// Seeds of one strip enter one per clock on the slave stream, sorted by
// reference start, with tuser marking the first seed and tlast the last one.
// A three-stage front works out the gap terms and products and feeds an
// eight-entry queue; the back updates the running chain score, one seed per
// clock unless a last seed waits on a full result register; this loop sets
// the sustained rate of one seed per cycle. Input is held off only when the
// queue plus the front stages are full. One transaction with the best chain's
// first and last index and its saturated score is registered after the last
// seed and offered on the master stream once no earlier result waits there.
// Configuration writes are meant for idle periods between strips.
// ----------------------------------------------------------------------------
`include "seed_chain_gap_score_filter_unit_macros.svh"

module seed_chain_gap_score_filter_unit
#(
    parameter int MAX_SEEDS = 4096
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // query_start [31:0], ref_start [63:32], seed_length [83:64]
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [87:0]                           s_tdata,
    // first_seed [0]
    input  logic [0:0]                            s_tuser,
    input  logic                                  s_tlast,
    // chain_first_index [11:0], chain_last_index [23:12], chain_score [71:24]
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [71:0]                           m_tdata,
    input  logic                                  cfg_we,
    input  logic [scgsf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [scgsf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    scgsf_pkg::scgsf_cfg_t    cfg_reg;
    scgsf_pkg::scgsf_entry_t  push_entry, q_head;
    scgsf_pkg::scgsf_result_t result;
    logic                     q_push, q_pop;
    logic [scgsf_pkg::QCNT_W-1:0] q_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_score    <= 8'd2;
            cfg_reg.gap_open       <= 8'd4;
            cfg_reg.gap_extend     <= 8'd2;
            cfg_reg.max_gap_area   <= '0;
            cfg_reg.optimistic_gap <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                scgsf_pkg::CFG_MATCH_SCORE:    cfg_reg.match_score    <= cfg_wdata[7:0];
                scgsf_pkg::CFG_GAP_OPEN:       cfg_reg.gap_open       <= cfg_wdata[7:0];
                scgsf_pkg::CFG_GAP_EXTEND:     cfg_reg.gap_extend     <= cfg_wdata[7:0];
                scgsf_pkg::CFG_MAX_GAP_AREA:   cfg_reg.max_gap_area   <= cfg_wdata;
                scgsf_pkg::CFG_OPTIMISTIC_GAP: cfg_reg.optimistic_gap <= cfg_wdata[0];
                default:                       cfg_reg                <= cfg_reg;
            endcase
        end
    end

    scgsf_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .query_start (s_tdata[31:0]),
        .ref_start   (s_tdata[63:32]),
        .seed_length (s_tdata[83:64]),
        .first_seed  (s_tuser[0]),
        .last_seed   (s_tlast),
        .cfg         (cfg_reg),
        .q_count     (q_count),
        .push        (q_push),
        .push_entry  (push_entry)
    );

    scgsf_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (q_head),
        .count      (q_count)
    );

    scgsf_back #(
        .MAX_SEEDS (MAX_SEEDS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_count != '0),
        .head      (q_head),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    assign m_tdata = {result.chain_score, result.chain_last_index, result.chain_first_index};

    // credit scheme must keep the queue from overflowing
    `SCGSF_ASSERT_IMPLY(a_queue_no_overflow, q_push && !q_pop, q_count != scgsf_pkg::QDEPTH, "queue overflow")
    `SCGSF_ASSERT_IMPLY(a_queue_no_underflow, q_pop, q_count != '0, "queue pop while empty")
    `SCGSF_ASSERT_IMPLY(a_ready_has_room, s_tready, q_count < scgsf_pkg::QDEPTH, "ready with full queue")

endmodule

>>> tb/sv/tb_seed_chain_gap_score_filter_unit.sv
// ----------------------------------------------------------------------------
// tb_seed_chain_gap_score_filter_unit
// self-checking bench for the seed chain gap score filter
// ----------------------------------------------------------------------------
// Seeds go in on the slave stream, one transaction per seed, and every best
// chain that comes back on the master stream is checked field by field
// against a cycle-free score model kept in the bench. Named tests cover
// hand-picked seeds, register corner settings, score saturation, output
// back-pressure that fills the block, and random strips under several
// register settings; gaps_on adds random idle bursts on both streams.
// ----------------------------------------------------------------------------
module tb_seed_chain_gap_score_filter_unit;

    localparam int          SEEDS_MAX      = 4096;
    localparam int unsigned CYCLE_LIMIT    = 600000;
    localparam int unsigned SETTLE_CYCLES  = 30;
    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned PHASE_ITEMS    = 70;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    // query_start [31:0], ref_start [63:32], seed_length [83:64]
    logic [87:0]                      s_tdata   = '0;
    // first_seed [0]
    logic [0:0]                       s_tuser   = '0;
    logic                             s_tlast   = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    // chain_first_index [11:0], chain_last_index [23:12], chain_score [71:24]
    logic [71:0]                      m_tdata;
    logic                             cfg_we    = 1'b0;
    logic [scgsf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [scgsf_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    seed_chain_gap_score_filter_unit #(
        .MAX_SEEDS (SEEDS_MAX)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    // score model state
    scgsf_pkg::scgsf_cfg_t           cfg_shadow;
    logic [scgsf_pkg::SCORE_W-1:0]   run_score;
    logic [scgsf_pkg::SCORE_W-1:0]   best_score;
    logic [11:0]                     chain_start;
    logic [11:0]                     best_first;
    logic [11:0]                     best_last;
    logic [11:0]                     seed_idx;
    logic [scgsf_pkg::POS_W-1:0]     prev_q;
    logic [scgsf_pkg::POS_W-1:0]     prev_r;
    logic [scgsf_pkg::LEN_W-1:0]     prev_len;
    scgsf_pkg::scgsf_result_t        best_chain_q[$];

    int                   errors        = 0;
    int unsigned          cycle_count   = 0;
    bit                   gaps_on       = 1'b1;
    int unsigned          rx_hold_trig  = 0;
    int unsigned          rx_hold_seen  = 0;
    int unsigned          rx_hold_left  = 0;
    int unsigned          rx_stall_left = 0;

    function automatic logic [scgsf_pkg::SCORE_W-1:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > {16'd0, scgsf_pkg::SCORE_MAX}) ? scgsf_pkg::SCORE_MAX
                                                   : s[scgsf_pkg::SCORE_W-1:0];
    endfunction

    function automatic void score_seed(logic [scgsf_pkg::POS_W-1:0] qs,
                                       logic [scgsf_pkg::POS_W-1:0] rs,
                                       logic [scgsf_pkg::LEN_W-1:0] len, bit first, bit last);
        logic [63:0]              gap;
        logic [63:0]              dr;
        logic [63:0]              q_end;
        logic [63:0]              r_end;
        logic [63:0]              gx;
        logic [63:0]              gy;
        logic                     cut;
        scgsf_pkg::scgsf_result_t res;
        if (first)
        begin
            seed_idx    = '0;
            run_score   = 48'(cfg_shadow.match_score) * len;
            best_score  = run_score;
            chain_start = '0;
            best_first  = '0;
            best_last   = '0;
        end
        else
        begin
            if (seed_idx < SEEDS_MAX - 1)
                seed_idx = seed_idx + 1'b1;
            run_score = sat_add(64'(run_score), 64'(cfg_shadow.match_score) * len);
            gap = '0;
            if (qs > prev_q)
                gap = 64'(qs) - prev_q;
            if (rs > prev_r)
            begin
                dr = 64'(rs) - prev_r;
                if (dr < gap)
                begin
                    gap = gap - dr;
                    if (cfg_shadow.optimistic_gap)
                        run_score = sat_add(64'(run_score),
                                            64'(cfg_shadow.match_score) * dr);
                end
                else
                begin
                    if (cfg_shadow.optimistic_gap)
                        run_score = sat_add(64'(run_score),
                                            64'(cfg_shadow.match_score) * gap);
                    gap = dr - gap;
                end
            end
            gap = gap * cfg_shadow.gap_extend;
            if (gap != 0)
                gap = gap + cfg_shadow.gap_open;
            q_end = 64'(prev_q) + prev_len;
            r_end = 64'(prev_r) + prev_len;
            gy = (qs < q_end) ? 64'd0 : 64'(qs) - q_end;
            gx = (rs < r_end) ? 64'd0 : 64'(rs) - r_end;
            cut = (cfg_shadow.max_gap_area != 0 && gx * gy > cfg_shadow.max_gap_area)
                  || (run_score < gap);
            if (cut)
            begin
                run_score   = '0;
                chain_start = seed_idx;
            end
            else
                run_score = run_score - gap[scgsf_pkg::SCORE_W-1:0];
            // strictly larger only, ties keep the older chain
            if (run_score > best_score)
            begin
                best_score = run_score;
                best_first = chain_start;
                best_last  = seed_idx;
            end
        end
        prev_q   = qs;
        prev_r   = rs;
        prev_len = len;
        if (last)
        begin
            res.chain_first_index = best_first;
            res.chain_last_index  = best_last;
            res.chain_score       = best_score;
            best_chain_q.insert(best_chain_q.size(), res);
        end
    endfunction

    // receiver: random short stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (rx_hold_trig != rx_hold_seen)
        begin
            rx_hold_seen <= rx_hold_trig;
            rx_hold_left <= RX_HOLD_CYCLES;
            m_tready     <= 1'b0;
        end
        else if (rx_hold_left != 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
            m_tready     <= 1'b0;
        end
        else if (rx_stall_left != 0)
        begin
            rx_stall_left <= rx_stall_left - 1;
            m_tready      <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            rx_stall_left <= $urandom_range(0, 3);
            m_tready      <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // result checker
    always @(posedge clk)
    begin
        scgsf_pkg::scgsf_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (best_chain_q.size() == 0)
            begin
                $display("%0t: result with none pending, actual %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = best_chain_q.pop_front();
                if (m_tdata[11:0] !== want.chain_first_index)
                begin
                    $display("%0t: chain_first_index expected %0d actual %0d",
                             $time, want.chain_first_index, m_tdata[11:0]);
                    errors++;
                end
                if (m_tdata[23:12] !== want.chain_last_index)
                begin
                    $display("%0t: chain_last_index expected %0d actual %0d",
                             $time, want.chain_last_index, m_tdata[23:12]);
                    errors++;
                end
                if (m_tdata[71:24] !== want.chain_score)
                begin
                    $display("%0t: chain_score expected %0d actual %0d",
                             $time, want.chain_score, m_tdata[71:24]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_seed_chain_gap_score_filter_unit: errors");
            $finish;
        end
    end

    task automatic send_seed(logic [scgsf_pkg::POS_W-1:0] qs, logic [scgsf_pkg::POS_W-1:0] rs,
                             logic [scgsf_pkg::LEN_W-1:0] len, bit first, bit last);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, len, rs, qs};
        s_tuser  <= first;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        score_seed(qs, rs, len, first, last);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (best_chain_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [scgsf_pkg::CFG_IDX_W-1:0] idx,
                             logic [scgsf_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // only called with the block idle
    task automatic set_config(logic [7:0] ms, logic [7:0] go, logic [7:0] ge,
                              logic [31:0] area, logic opt);
        write_reg(scgsf_pkg::CFG_MATCH_SCORE, 32'(ms));
        write_reg(scgsf_pkg::CFG_GAP_OPEN, 32'(go));
        write_reg(scgsf_pkg::CFG_GAP_EXTEND, 32'(ge));
        write_reg(scgsf_pkg::CFG_MAX_GAP_AREA, area);
        write_reg(scgsf_pkg::CFG_OPTIMISTIC_GAP, 32'(opt));
        cfg_we <= 1'b0;
        cfg_shadow.match_score    = ms;
        cfg_shadow.gap_open       = go;
        cfg_shadow.gap_extend     = ge;
        cfg_shadow.max_gap_area   = area;
        cfg_shadow.optimistic_gap = opt;
    endtask

    // mostly chainable seeds along a diagonal, with occasional jumps
    task automatic send_strip(int unsigned n, bit with_first, bit with_last);
        logic [scgsf_pkg::POS_W-1:0] q;
        logic [scgsf_pkg::POS_W-1:0] r;
        logic [scgsf_pkg::LEN_W-1:0] len;
        int unsigned                 step;
        q = $urandom_range(0, 5000);
        r = $urandom_range(0, 5000);
        for (int unsigned i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 19))
                0:
                begin
                    q = $urandom;
                    r = $urandom;
                end
                1: q = q + $urandom_range(500, 100000);
                2: r = r + $urandom_range(500, 100000);
                3: ;
                default:
                begin
                    step = $urandom_range(0, 60);
                    q = q + step + $urandom_range(0, 8);
                    r = r + step + $urandom_range(0, 8);
                end
            endcase
            len = ($urandom_range(0, 30) == 0) ? 20'($urandom) : 20'($urandom_range(0, 40));
            send_seed(q, r, len, with_first && i == 0, with_last && i == n - 1);
        end
    endtask

    task automatic test_directed();
        // no first seed since reset, chained to a virtual seed at the origin
        send_seed(32'd100, 32'd50, 20'd10, 1'b0, 1'b0);
        send_seed(32'd200, 32'd300, 20'd5, 1'b0, 1'b1);
        // equal scores must not replace the best chain
        send_seed(32'd0, 32'd0, 20'd10, 1'b1, 1'b0);
        send_seed(32'd1000, 32'd0, 20'd10, 1'b0, 1'b0);
        send_seed(32'd1010, 32'd10, 20'd10, 1'b0, 1'b0);
        send_seed(32'd1020, 32'd20, 20'd0, 1'b0, 1'b1);
        // single seed strip
        send_seed(32'd0, 32'd0, 20'hFFFFF, 1'b1, 1'b1);
        for (int pass = 0; pass < 2; pass++)
        begin
            send_seed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF, 1'b1, 1'b0);
            send_seed(32'd0, 32'd0, 20'd0, 1'b0, 1'b0);
            send_seed(32'hFFFF_FFFF, 32'd0, 20'hFFFFF, 1'b0, 1'b0);
            send_seed(32'd0, 32'hFFFF_FFFF, 20'd0, 1'b0, 1'b1);
            wait_results_drained();
            set_config(8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF, 1'b1);
        end
        // diagonal reward taken from both the query and the reference side
        send_seed(32'd10, 32'd10, 20'd3, 1'b1, 1'b0);
        send_seed(32'd20, 32'd30, 20'd3, 1'b0, 1'b0);
        send_seed(32'd40, 32'd35, 20'd3, 1'b0, 1'b1);
        wait_results_drained();
    endtask

    task automatic test_config_corners();
        set_config(8'd0, 8'd0, 8'd0, 32'd0, 1'b0);
        send_strip(10, 1'b1, 1'b1);
        wait_results_drained();
        set_config(8'd9, 8'd1, 8'd1, 32'd1, 1'b1);
        send_strip(10, 1'b1, 1'b1);
        wait_results_drained();
    endtask

    task automatic test_score_saturation();
        set_config(8'd255, 8'd0, 8'd0, 32'd0, 1'b1);
        for (int i = 0; i < 600; i++)
        begin
            if (i % 2 == 0)
                send_seed(32'd0, 32'd0, 20'hFFFFF, i == 0, 1'b0);
            else
                send_seed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF, 1'b0, i == 599);
        end
        wait_results_drained();
    endtask

    task automatic test_backpressure();
        set_config(8'd3, 8'd5, 8'd1, 32'd100000, 1'b0);
        rx_hold_trig <= rx_hold_trig + 1;
        for (int i = 0; i < 40; i++)
            send_strip(2, 1'b1, 1'b1);
        // sender holds off until every chain is out
        wait_results_drained();
    endtask

    task automatic test_random_strips(int unsigned phases, bit idle);
        int unsigned sent;
        int unsigned n;
        logic [7:0]  ms;
        logic [7:0]  go;
        logic [7:0]  ge;
        logic [31:0] area;
        gaps_on = idle;
        for (int unsigned p = 0; p < phases; p++)
        begin
            ms   = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
            go   = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 10));
            ge   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
            case ($urandom_range(0, 3))
                0: area = 32'd0;
                1: area = $urandom_range(1, 5000);
                2: area = $urandom_range(5000, 2000000);
                default: area = $urandom;
            endcase
            set_config(ms, go, ge, area, 1'($urandom));
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        send_seed($urandom, $urandom, 20'($urandom), 1'($urandom),
                                  1'($urandom));
                        sent++;
                    end
                    1:
                    begin
                        // broken strip: a missing first or last marker
                        n = $urandom_range(1, 8);
                        if ($urandom_range(0, 1))
                            send_strip(n, 1'b0, 1'b1);
                        else
                            send_strip(n, 1'b1, 1'b0);
                        sent += n;
                    end
                    default:
                    begin
                        n = $urandom_range(1, 12);
                        send_strip(n, 1'b1, 1'b1);
                        sent += n;
                    end
                endcase
            end
            wait_results_drained();
        end
    endtask

    initial
    begin
        cfg_shadow.match_score    = 8'd2;
        cfg_shadow.gap_open       = 8'd4;
        cfg_shadow.gap_extend     = 8'd2;
        cfg_shadow.max_gap_area   = 32'd0;
        cfg_shadow.optimistic_gap = 1'b0;
        run_score   = '0;
        best_score  = '0;
        chain_start = '0;
        best_first  = '0;
        best_last   = '0;
        seed_idx    = '0;
        prev_q      = '0;
        prev_r      = '0;
        prev_len    = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_corners();
        test_score_saturation();
        test_backpressure();
        test_random_strips(6, 1'b1);
        test_random_strips(2, 1'b0);

        if (errors == 0 && best_chain_q.size() == 0)
            $display("tb_seed_chain_gap_score_filter_unit: clean");
        else
            $display("tb_seed_chain_gap_score_filter_unit: errors");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/scgsf_pkg.sv
src/scgsf_front.sv
src/scgsf_queue.sv
src/scgsf_back.sv
src/seed_chain_gap_score_filter_unit.sv
tb/sv/tb_seed_chain_gap_score_filter_unit.sv
